>>> hw/rtl/ahfe_pkg.sv
package ahfe_pkg;

    localparam logic [31:0] C_FORMAT_HCA   = 32'd26;
    localparam logic [31:0] C_MAGIC_HCA    = 32'h4843_4100;  // 'H','C','A',0
    localparam logic [31:0] C_TAG_FMT      = 32'h666D_7400;  // 'f','m','t',0
    localparam logic [31:0] C_TAG_COMP     = 32'h636F_6D70;  // 'c','o','m','p'
    localparam logic [3:0]  C_FMT_DONE     = 4'd13;
    localparam logic [1:0]  C_COMP_DONE    = 2'd3;
    localparam int          C_FRAME_SHIFT  = 10;             // 1024 frames per block

    localparam int          C_IN_TDATA_W   = 40;
    localparam int          C_OUT_TDATA_W  = 128;
    localparam int          C_FRAMES_W     = 42;

    typedef struct packed {
        logic        magic;
        logic        fmt_done;
        logic        comp_done;
        logic [7:0]  channels;
        logic [23:0] rate;
        logic [31:0] blocks;
        logic [15:0] delay;
        logic [15:0] padding;
        logic [15:0] block_size;
    } t_scan_info;

endpackage

>>> hw/rtl/ahfe_scan.sv
module ahfe_scan (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [7:0]            i_byte,
    input  logic                  i_last,
    output ahfe_pkg::t_scan_info  o_next
);

    logic [23:0] r_window,   n_window;
    logic        r_magic,    n_magic;
    logic [3:0]  r_fmt_prog, n_fmt_prog;
    logic [1:0]  r_comp_prog, n_comp_prog;
    logic [7:0]  r_channels, n_channels;
    logic [23:0] r_rate,     n_rate;
    logic [31:0] r_blocks,   n_blocks;
    logic [15:0] r_delay,    n_delay;
    logic [15:0] r_padding,  n_padding;
    logic [15:0] r_bsize,    n_bsize;
    logic [31:0] quad;

    always_comb begin
        quad        = {r_window, i_byte};
        n_window    = quad[23:0];
        n_magic     = r_magic;
        n_fmt_prog  = r_fmt_prog;
        n_comp_prog = r_comp_prog;
        n_channels  = r_channels;
        n_rate      = r_rate;
        n_blocks    = r_blocks;
        n_delay     = r_delay;
        n_padding   = r_padding;
        n_bsize     = r_bsize;
        if (r_magic) begin
            // capture the 12 bytes after the fmt tag, big-endian
            if (r_fmt_prog != 4'd0 && r_fmt_prog < ahfe_pkg::C_FMT_DONE) begin
                case (r_fmt_prog) inside
                    4'd1:          n_channels = i_byte;
                    [4'd2:4'd4]:   n_rate     = {r_rate[15:0], i_byte};
                    [4'd5:4'd8]:   n_blocks   = {r_blocks[23:0], i_byte};
                    [4'd9:4'd10]:  n_delay    = {r_delay[7:0], i_byte};
                    default:       n_padding  = {r_padding[7:0], i_byte};
                endcase
                n_fmt_prog = r_fmt_prog + 4'd1;
            end else if (r_fmt_prog == 4'd0 && quad == ahfe_pkg::C_TAG_FMT) begin
                n_fmt_prog = 4'd1;
            end
            if (r_comp_prog != 2'd0 && r_comp_prog != ahfe_pkg::C_COMP_DONE) begin
                n_bsize     = {r_bsize[7:0], i_byte};
                n_comp_prog = r_comp_prog + 2'd1;
            end else if (r_comp_prog == 2'd0 && quad == ahfe_pkg::C_TAG_COMP) begin
                n_comp_prog = 2'd1;
            end
        end else if (quad == ahfe_pkg::C_MAGIC_HCA) begin
            n_magic = 1'b1;
        end
    end

    always_comb begin
        o_next.magic      = n_magic;
        o_next.fmt_done   = (n_fmt_prog == ahfe_pkg::C_FMT_DONE);
        o_next.comp_done  = (n_comp_prog == ahfe_pkg::C_COMP_DONE);
        o_next.channels   = n_channels;
        o_next.rate       = n_rate;
        o_next.blocks     = n_blocks;
        o_next.delay      = n_delay;
        o_next.padding    = n_padding;
        o_next.block_size = n_bsize;
    end

    // clear everything after the final byte of an entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_window    <= '0;
            r_magic     <= 1'b0;
            r_fmt_prog  <= '0;
            r_comp_prog <= '0;
            r_channels  <= '0;
            r_rate      <= '0;
            r_blocks    <= '0;
            r_delay     <= '0;
            r_padding   <= '0;
            r_bsize     <= '0;
        end else if (i_step) begin
            r_window    <= n_window;
            r_magic     <= n_magic;
            r_fmt_prog  <= n_fmt_prog;
            r_comp_prog <= n_comp_prog;
            r_channels  <= n_channels;
            r_rate      <= n_rate;
            r_blocks    <= n_blocks;
            r_delay     <= n_delay;
            r_padding   <= n_padding;
            r_bsize     <= n_bsize;
        end
    end

endmodule

>>> hw/rtl/audio_header_field_extractor.sv
// Result path: the last byte passes the input register, then the result register, where the result becomes valid.
// Throughput: one byte per cycle; bytes that are not last keep flowing while a
// finished result waits on the master side, and a last byte holds in the input
// register until the result register is free.
// Reset: synchronous, active low; clears the pipeline valids and all scan state.
module audio_header_field_extractor (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [7:0] data_byte, [39:8] format_code
    input  logic [39:0]  i_s_axis_tdata,
    input  logic         i_s_axis_tlast,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [7:0] channel_count, [31:8] sample_rate, [63:32] block_total,
    // [105:64] frame_total, [121:106] block_bytes, [127:122] zero
    output logic [127:0] o_m_axis_tdata
);

    logic                              r_in_valid;
    logic [7:0]                        r_in_byte;
    logic                              r_in_last;
    logic [31:0]                       r_in_format;
    logic                              r_out_valid;
    logic [ahfe_pkg::C_OUT_TDATA_W-1:0] r_out_data, n_out_data;
    logic                              out_free;
    logic                              advance;
    logic                              fmt_ok;
    logic                              comp_ok;
    logic [ahfe_pkg::C_FRAMES_W-1:0]   total;
    logic [ahfe_pkg::C_FRAMES_W-1:0]   cut;
    logic [ahfe_pkg::C_FRAMES_W-1:0]   frames;
    ahfe_pkg::t_scan_info              scan;

    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign advance         = r_in_valid && (!r_in_last || out_free);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    ahfe_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (advance),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_next  (scan)
    );

    always_comb begin
        fmt_ok  = (r_in_format == ahfe_pkg::C_FORMAT_HCA) && scan.magic && scan.fmt_done;
        comp_ok = (r_in_format == ahfe_pkg::C_FORMAT_HCA) && scan.magic && scan.comp_done;
        total   = {scan.blocks, {ahfe_pkg::C_FRAME_SHIFT{1'b0}}};
        cut     = ahfe_pkg::C_FRAMES_W'({1'b0, scan.delay} + {1'b0, scan.padding});
        frames  = (fmt_ok && total > cut) ? total - cut : '0;
        n_out_data = '0;
        if (fmt_ok) begin
            n_out_data[7:0]   = scan.channels;
            n_out_data[31:8]  = scan.rate;
            n_out_data[63:32] = scan.blocks;
        end
        n_out_data[105:64] = frames;
        if (comp_ok) begin
            n_out_data[121:106] = scan.block_size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready) begin
                r_in_valid <= i_s_axis_tvalid;
            end
            if (advance && r_in_last) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_byte   <= i_s_axis_tdata[7:0];
            r_in_format <= i_s_axis_tdata[39:8];
            r_in_last   <= i_s_axis_tlast;
        end
        if (advance && r_in_last) begin
            r_out_data <= n_out_data;
        end
    end

endmodule
